// ===== sv/bfra_pkg.sv =====
// Package for the bitmap free-run analyzer: widths, scan state and result types,
// saturating add and output clipping helpers. No dependencies.
package bfra_pkg;

	localparam int IDX_W = 32;
	localparam int OUT_W = 32;
	localparam int CFG_W = 32;
	localparam int CMP_W = (IDX_W > CFG_W) ? IDX_W : CFG_W;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [OUT_W-1:0] out_t;
	typedef logic [CFG_W-1:0] cfg_t;
	typedef logic [CMP_W-1:0] cmp_t;

	typedef struct packed {
		idx_t cluster_position;
		idx_t run_length;
		idx_t run_start;
		idx_t free_total;
		idx_t run_total;
		idx_t max_run;
		idx_t first_free_index;
		logic first_seen;
		idx_t last_free_index;
		logic fit_flag;
		idx_t fit_index;
	} scan_state_t;

	typedef struct packed {
		out_t free_clusters;
		out_t free_runs;
		out_t longest_run;
		out_t first_free;
		out_t last_free;
		logic fit_found;
		out_t fit_start;
	} result_t;

	function automatic idx_t sat_add(idx_t a, idx_t b);
		logic [IDX_W:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[IDX_W] ? '1 : sum[IDX_W-1:0];
	endfunction

	function automatic out_t clip(idx_t v);
		logic [IDX_W+OUT_W-1:0] w;
		logic [IDX_W+OUT_W-1:0] lim;
		w = {{OUT_W{1'b0}}, v};
		lim = {{IDX_W{1'b0}}, {OUT_W{1'b1}}};
		return (w > lim) ? '1 : w[OUT_W-1:0];
	endfunction

endpackage

// ===== sv/bfra_ifs.sv =====
// Channel interfaces of the bitmap free-run analyzer: bitmap byte input and result output.
// Depends on bfra_pkg for field widths.
interface bfra_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] bitmap_byte;
	logic       last_byte;

	modport source (output valid, output bitmap_byte, output last_byte, input ready);
	modport sink   (input valid, input bitmap_byte, input last_byte, output ready);
endinterface

interface bfra_out_if;
	logic          valid;
	logic          ready;
	bfra_pkg::out_t free_clusters;
	bfra_pkg::out_t free_runs;
	bfra_pkg::out_t longest_run;
	bfra_pkg::out_t first_free;
	bfra_pkg::out_t last_free;
	logic          fit_found;
	bfra_pkg::out_t fit_start;

	modport source (output valid, output free_clusters, output free_runs, output longest_run,
		output first_free, output last_free, output fit_found, output fit_start, input ready);
	modport sink   (input valid, input free_clusters, input free_runs, input longest_run,
		input first_free, input last_free, input fit_found, input fit_start, output ready);
endinterface

// ===== sv/bfra_byte_update.sv =====
// Next scan state after eight clusters of one bitmap byte, in closed form per byte.
// Depends on bfra_pkg.
module bfra_byte_update (
	input  bfra_pkg::scan_state_t cur,
	input  logic [7:0]            bitmap_byte,
	input  bfra_pkg::cfg_t        required_length,
	output bfra_pkg::scan_state_t nxt
);

	always_comb begin
		logic [7:0]     f;
		logic [3:0]     run_len [8];
		logic [7:0]     starts;
		logic [3:0]     trail;
		logic [3:0]     free_cnt;
		logic [3:0]     new_runs;
		logic [3:0]     int_max;
		logic [2:0]     low_j;
		logic [2:0]     high_j;
		logic [2:0]     start_j;
		logic [2:0]     fit_j;
		logic           have_start;
		logic           have_fit;
		logic           any_free;
		logic           cont0;
		logic           cont;
		bfra_pkg::idx_t l0;
		bfra_pkg::cmp_t need;

		f = ~bitmap_byte;
		need = (required_length == '0) ? bfra_pkg::CMP_W'(1) : bfra_pkg::CMP_W'(required_length);
		cont0 = (cur.run_length != '0);

		for (int j = 0; j < 8; j++) begin
			run_len[j] = '0;
			cont = 1'b1;
			for (int k = 0; k < 8; k++) begin
				if (k >= j) begin
					if (cont && f[k]) begin
						run_len[j] = run_len[j] + 4'd1;
					end else begin
						cont = 1'b0;
					end
				end
			end
		end

		starts[0] = f[0] & ~cont0;
		for (int j = 1; j < 8; j++) begin
			starts[j] = f[j] & ~f[j-1];
		end

		trail = '0;
		cont = 1'b1;
		for (int j = 7; j >= 0; j--) begin
			if (cont && f[j]) begin
				trail = trail + 4'd1;
			end else begin
				cont = 1'b0;
			end
		end

		free_cnt = '0;
		new_runs = '0;
		for (int j = 0; j < 8; j++) begin
			free_cnt = free_cnt + 4'(f[j]);
			new_runs = new_runs + 4'(starts[j]);
		end

		any_free = |f;
		low_j = '0;
		high_j = '0;
		for (int j = 7; j >= 0; j--) begin
			if (f[j]) begin
				low_j = 3'(j);
			end
		end
		for (int j = 0; j < 8; j++) begin
			if (f[j]) begin
				high_j = 3'(j);
			end
		end

		int_max = '0;
		have_start = 1'b0;
		start_j = '0;
		have_fit = 1'b0;
		fit_j = '0;
		for (int j = 1; j < 8; j++) begin
			if (starts[j]) begin
				have_start = 1'b1;
				start_j = 3'(j);
				if (run_len[j] > int_max) begin
					int_max = run_len[j];
				end
			end
		end
		for (int j = 7; j >= 1; j--) begin
			if (starts[j] && (bfra_pkg::CMP_W'(run_len[j]) >= need)) begin
				have_fit = 1'b1;
				fit_j = 3'(j);
			end
		end

		l0 = bfra_pkg::sat_add(cur.run_length, bfra_pkg::IDX_W'(run_len[0]));

		nxt = cur;
		nxt.cluster_position = bfra_pkg::sat_add(cur.cluster_position, bfra_pkg::IDX_W'(8));
		nxt.free_total = bfra_pkg::sat_add(cur.free_total, bfra_pkg::IDX_W'(free_cnt));
		nxt.run_total = bfra_pkg::sat_add(cur.run_total, bfra_pkg::IDX_W'(new_runs));
		nxt.run_length = (f == 8'hFF) ? l0 : bfra_pkg::IDX_W'(trail);

		if (have_start) begin
			nxt.run_start = bfra_pkg::sat_add(cur.cluster_position, bfra_pkg::IDX_W'(start_j));
		end else if (starts[0]) begin
			nxt.run_start = cur.cluster_position;
		end

		if (any_free) begin
			nxt.last_free_index = bfra_pkg::sat_add(cur.cluster_position,
				bfra_pkg::IDX_W'(high_j));
			if (!cur.first_seen) begin
				nxt.first_seen = 1'b1;
				nxt.first_free_index = bfra_pkg::sat_add(cur.cluster_position,
					bfra_pkg::IDX_W'(low_j));
			end
		end

		if (f[0] && (l0 > nxt.max_run)) begin
			nxt.max_run = l0;
		end
		if (bfra_pkg::IDX_W'(int_max) > nxt.max_run) begin
			nxt.max_run = bfra_pkg::IDX_W'(int_max);
		end

		if (!cur.fit_flag) begin
			if (f[0] && (bfra_pkg::CMP_W'(l0) >= need)) begin
				nxt.fit_flag = 1'b1;
				nxt.fit_index = cont0 ? cur.run_start : cur.cluster_position;
			end else if (have_fit) begin
				nxt.fit_flag = 1'b1;
				nxt.fit_index = bfra_pkg::sat_add(cur.cluster_position, bfra_pkg::IDX_W'(fit_j));
			end
		end
	end

endmodule

// ===== sv/bfra_result_reg.sv =====
// Result register: maps the final scan state to result fields and holds them for transfer.
// Depends on bfra_pkg and bfra_out_if.
module bfra_result_reg (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  bfra_pkg::scan_state_t fin,
	output logic                  free_slot,
	bfra_out_if.source            result_out
);

	bfra_pkg::result_t res_d;
	bfra_pkg::result_t res_q;
	logic              valid_q;

	always_comb begin
		res_d.free_clusters = bfra_pkg::clip(fin.free_total);
		res_d.free_runs     = bfra_pkg::clip(fin.run_total);
		res_d.longest_run   = bfra_pkg::clip(fin.max_run);
		res_d.first_free    = bfra_pkg::clip(fin.first_seen ? fin.first_free_index
			: fin.cluster_position);
		res_d.last_free     = bfra_pkg::clip(fin.first_seen ? fin.last_free_index : '0);
		res_d.fit_found     = fin.fit_flag;
		res_d.fit_start     = bfra_pkg::clip(fin.fit_flag ? fin.fit_index : '0);
	end

	assign free_slot = !valid_q || result_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (result_out.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_d;
		end
	end

	assign result_out.valid         = valid_q;
	assign result_out.free_clusters = res_q.free_clusters;
	assign result_out.free_runs     = res_q.free_runs;
	assign result_out.longest_run   = res_q.longest_run;
	assign result_out.first_free    = res_q.first_free;
	assign result_out.last_free     = res_q.last_free;
	assign result_out.fit_found     = res_q.fit_found;
	assign result_out.fit_start     = res_q.fit_start;

endmodule

// ===== sv/bitmap_free_run_analyzer.sv =====
// Bitmap free-run analyzer top level: input register, scan state, result register.
// Depends on bfra_pkg, bfra_ifs, bfra_byte_update and bfra_result_reg.
//
// bitmap_in takes one allocation bitmap byte per transfer, LSB the lowest cluster,
// 1 meaning used; last_byte closes the scan. result_out gives one item per scan:
// free count, run count, longest run, first and last free cluster and the first
// run of at least required_length clusters with its found flag.
// A byte sits in the input register while all eight clusters update the scan state as
// it leaves; the result register loads as a scan's last byte leaves. One byte per cycle
// is taken sustained unless a closing byte waits for the result slot. A following scan
// starts on the next byte with no gap. When result_out stalls, the result is held;
// bytes that do not close a scan keep flowing, and a closing byte waits in the input
// register until the result slot frees. cfg_wr_en/cfg_wr_data write required_length
// (reset value 1) between scans, a rule the user keeps; the block does not enforce it.
// Reset clears the scan state, both valid flags and sets required_length to 1.
module bitmap_free_run_analyzer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  bfra_pkg::cfg_t    cfg_wr_data,
	bfra_in_if.sink           bitmap_in,
	bfra_out_if.source        result_out
);

	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  last_s1;
	logic                  advance;
	logic                  free_slot;
	bfra_pkg::cfg_t        req_len_q;
	bfra_pkg::scan_state_t state_q;
	bfra_pkg::scan_state_t state_nxt;

	assign advance         = valid_s1 && (!last_s1 || free_slot);
	assign bitmap_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_len_q <= bfra_pkg::CFG_W'(1);
		end else if (cfg_wr_en) begin
			req_len_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bitmap_in.ready) begin
			valid_s1 <= bitmap_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bitmap_in.ready && bitmap_in.valid) begin
			byte_s1 <= bitmap_in.bitmap_byte;
			last_s1 <= bitmap_in.last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= last_s1 ? '0 : state_nxt;
		end
	end

	bfra_byte_update u_update (
		.cur             (state_q),
		.bitmap_byte     (byte_s1),
		.required_length (req_len_q),
		.nxt             (state_nxt)
	);

	bfra_result_reg u_result (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (advance && last_s1),
		.fin        (state_nxt),
		.free_slot  (free_slot),
		.result_out (result_out)
	);

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for bitmap_free_run_analyzer: streams allocation bitmap scans,
// predicts each scan report in a small scoreboard class and checks it on result_out.
// Depends on bfra_pkg, bfra_ifs and the bitmap_free_run_analyzer RTL.
module tb_top;
	import bfra_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 4;
	localparam int PHASE_BYTES    = 160;

	class free_run_tracker;
		logic [63:0] cnt_max;
		logic [63:0] need_length;
		logic [63:0] position;
		logic [63:0] run_len;
		logic [63:0] run_begin;
		logic [63:0] free_count;
		logic [63:0] run_count;
		logic [63:0] longest;
		logic [63:0] first_idx;
		bit          seen_free;
		logic [63:0] last_idx;
		bit          fit_hit;
		logic [63:0] fit_idx;
		result_t     expected_reports[$];
		int          errors;

		function new();
			cnt_max = (64'd1 << IDX_W) - 64'd1;
			need_length = 64'd1;
			errors = 0;
			clear_scan();
		endfunction

		function void clear_scan();
			position = 0;
			run_len = 0;
			run_begin = 0;
			free_count = 0;
			run_count = 0;
			longest = 0;
			first_idx = 0;
			seen_free = 0;
			last_idx = 0;
			fit_hit = 0;
			fit_idx = 0;
		endfunction

		function logic [63:0] sat_inc(logic [63:0] v);
			return (v >= cnt_max) ? cnt_max : v + 64'd1;
		endfunction

		function out_t clip32(logic [63:0] v);
			return (v > 64'hFFFF_FFFF) ? '1 : v[OUT_W-1:0];
		endfunction

		function void set_required(cfg_t v);
			need_length = {32'd0, v};
		endfunction

		function void scan_cluster(bit used);
			logic [63:0] need;
			if (used) begin
				run_len = 0;
			end else begin
				if (run_len == 0) begin
					run_begin = position;
					run_count = sat_inc(run_count);
				end
				run_len = sat_inc(run_len);
				free_count = sat_inc(free_count);
				if (!seen_free) begin
					seen_free = 1;
					first_idx = position;
				end
				last_idx = position;
				if (run_len > longest)
					longest = run_len;
				need = (need_length == 0) ? 64'd1 : need_length;
				if (!fit_hit && run_len >= need) begin
					fit_hit = 1;
					fit_idx = run_begin;
				end
			end
			position = sat_inc(position);
		endfunction

		function void note_byte(logic [7:0] b, logic last);
			result_t r;
			for (int j = 0; j < 8; j++)
				scan_cluster(b[j]);
			if (last) begin
				r.free_clusters = clip32(free_count);
				r.free_runs     = clip32(run_count);
				r.longest_run   = clip32(longest);
				r.first_free    = clip32(seen_free ? first_idx : position);
				r.last_free     = clip32(seen_free ? last_idx : 64'd0);
				r.fit_found     = fit_hit;
				r.fit_start     = clip32(fit_hit ? fit_idx : 64'd0);
				expected_reports.push_back(r);
				clear_scan();
			end
		endfunction

		function int pending();
			return expected_reports.size();
		endfunction

		function void check_report(result_t got);
			result_t exp;
			bit      ok;
			if (expected_reports.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected report: free %0d runs %0d", got.free_clusters,
						got.free_runs);
				return;
			end
			exp = expected_reports.pop_front();
			ok = (got.free_clusters === exp.free_clusters) && (got.free_runs === exp.free_runs)
				&& (got.longest_run === exp.longest_run) && (got.first_free === exp.first_free)
				&& (got.last_free === exp.last_free) && (got.fit_found === exp.fit_found)
				&& (got.fit_start === exp.fit_start);
			if (!ok) begin
				errors++;
				if (errors <= 10) begin
					$display("report mismatch: free %0d/%0d runs %0d/%0d longest %0d/%0d",
						exp.free_clusters, got.free_clusters, exp.free_runs, got.free_runs,
						exp.longest_run, got.longest_run);
					$display("  first %0d/%0d last %0d/%0d fit %0b/%0b start %0d/%0d (exp/got)",
						exp.first_free, got.first_free, exp.last_free, got.last_free,
						exp.fit_found, got.fit_found, exp.fit_start, got.fit_start);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	cfg_t cfg_wr_data;

	bfra_in_if  bm_ch();
	bfra_out_if res_ch();

	bitmap_free_run_analyzer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.bitmap_in  (bm_ch),
		.result_out (res_ch)
	);

	free_run_tracker tracker = new();
	bit sender_calm;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] pick_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30)
			return 8'($urandom_range(0, 255));
		else if (r < 50)
			return 8'h00;
		else if (r < 65)
			return 8'hFF;
		else if (r < 80)
			return 8'h01 << $urandom_range(0, 7);
		else if (r < 90)
			return ~(8'h01 << $urandom_range(0, 7));
		else if (r < 95)
			return 8'hFF << $urandom_range(0, 7);
		return 8'hFF >> $urandom_range(0, 7);
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = sender_calm ? 0 : pick_gap();
		if (gap > 0) begin
			bm_ch.valid <= 1'b0;
			bm_ch.bitmap_byte <= 8'($urandom);
			bm_ch.last_byte <= 1'($urandom);
			repeat (gap) @(posedge clk);
		end
		bm_ch.valid <= 1'b1;
		bm_ch.bitmap_byte <= b;
		bm_ch.last_byte <= last;
		do @(posedge clk); while (!bm_ch.ready);
		tracker.note_byte(b, last);
	endtask

	task automatic wait_drained();
		bm_ch.valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_required(input cfg_t v);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= 32'($urandom);
		tracker.set_required(v);
	endtask

	task automatic send_scan(input logic [7:0] bytes[$]);
		for (int i = 0; i < bytes.size(); i++)
			send_byte(bytes[i], i == bytes.size() - 1);
	endtask

	task automatic random_phase(input cfg_t req, input bit hold_midway);
		int sent;
		int len;
		int r;
		bit held;
		write_required(req);
		sent = 0;
		held = 0;
		while (sent < PHASE_BYTES) begin
			r = $urandom_range(0, 99);
			if (r < 75)
				len = $urandom_range(1, 8);
			else if (r < 95)
				len = $urandom_range(9, 30);
			else
				len = $urandom_range(31, 120);
			sender_calm = ($urandom_range(0, 4) == 0);
			for (int i = 0; i < len; i++)
				send_byte(pick_byte(), i == len - 1);
			sent += len;
			if (hold_midway && !held && sent >= PHASE_BYTES / 2) begin
				wait_drained();
				held = 1;
			end
		end
		sender_calm = 0;
	endtask

	initial begin
		cfg_t phase_req[8];
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		bm_ch.valid = 1'b0;
		bm_ch.bitmap_byte = 8'h00;
		bm_ch.last_byte = 1'b0;
		sender_calm = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		send_scan('{8'h00});
		send_scan('{8'hFF});
		send_scan('{8'hFE});
		send_scan('{8'h7F});
		send_scan('{8'h55});
		send_scan('{8'hAA});
		write_required(32'd0);
		send_scan('{8'hF0, 8'h0F});
		send_scan('{8'hFF, 8'hFF, 8'hFF});
		write_required(32'hFFFF_FFFF);
		send_scan('{8'h00, 8'h00});
		write_required(32'd5);
		send_scan('{8'h81, 8'hC3, 8'h00});
		send_scan('{8'hE0, 8'h03});

		phase_req[0] = 32'd1;
		phase_req[1] = 32'd0;
		phase_req[2] = 32'hFFFF_FFFF;
		phase_req[3] = 32'($urandom);
		phase_req[4] = 32'($urandom_range(2, 12));
		phase_req[5] = 32'($urandom_range(8, 40));
		phase_req[6] = 32'($urandom_range(1, 4));
		phase_req[7] = 32'd16;
		foreach (phase_req[p])
			random_phase(phase_req[p], p == 2);

		wait_drained();
		repeat (10) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		int stall_left;
		int calm_left;
		bit calm;
		result_t got;
		stall_left = 0;
		calm_left = 0;
		calm = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res_ch.valid && res_ch.ready) begin
				got.free_clusters = res_ch.free_clusters;
				got.free_runs     = res_ch.free_runs;
				got.longest_run   = res_ch.longest_run;
				got.first_free    = res_ch.first_free;
				got.last_free     = res_ch.last_free;
				got.fit_found     = res_ch.fit_found;
				got.fit_start     = res_ch.fit_start;
				tracker.check_report(got);
			end
			if (calm_left == 0) begin
				calm = ($urandom_range(0, 3) == 0);
				calm_left = $urandom_range(50, 300);
			end else begin
				calm_left--;
			end
			if (stall_left > 0) begin
				stall_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
				if (!calm)
					stall_left = pick_gap();
			end
		end
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		@(posedge arst_n);
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((bm_ch.valid && bm_ch.ready) || (res_ch.valid && res_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("status: fail");
		$finish;
	end

endmodule
